### rtl/rhep_pkg.sv
// Package for the RTP header-extension parser: payload types, codes and constants.
// Used by every other file of the parser but the stream interface; depends on nothing.
`timescale 1ns / 1ps

package rhep_pkg;

	// Profile words that select the element form
	localparam logic [15:0] PROFILE_ONE      = 16'hBEDE;
	localparam logic [15:0] PROFILE_TWO      = 16'h1000;
	localparam logic [15:0] PROFILE_TWO_MASK = 16'hFFF0;

	// One-byte form id that stops parsing of the rest of the block
	localparam logic [3:0] STOP_ID = 4'hF;

	// Block offset counter saturates here
	localparam logic [16:0] OFFSET_MAX = 17'h1FFFF;

	// Default bound on block length in bytes
	localparam int MAX_BLOCK_BYTES_DEF = 65535;

	// Depth of the record queue between parser and output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Input item: one byte of the extension block
	typedef struct packed {
		logic [7:0]  ext_byte;
		logic [15:0] profile;
		logic        end_of_block;
	} in_item_t;

	// Result item: one element record or one end-of-block status
	typedef struct packed {
		logic        record_type;
		logic [7:0]  ext_id;
		logic [7:0]  ext_len;
		logic [15:0] data_offset;
		logic        status;
		logic        run_last;
	} rec_t;

	// Record type codes
	localparam logic REC_ELEMENT = 1'b0;
	localparam logic REC_STATUS  = 1'b1;

	// Queue entry: all records caused by one input byte
	typedef struct packed {
		logic        elem_vld;
		logic [7:0]  elem_id;
		logic [7:0]  elem_len;
		logic [15:0] elem_off;
		logic        stat_vld;
		logic        stat_bad;
	} q_entry_t;

	// Parse phase, one-hot
	typedef enum logic [4:0] {
		PH_HDR  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_DATA = 5'b00100,
		PH_SKIP = 5'b01000,
		PH_BAD  = 5'b10000
	} phase_t;

	// Element form of the current block
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_TWO  = 2'd2,
		MODE_IGN  = 2'd3
	} mode_t;

endpackage

### rtl/rhep_stream_if.sv
// Valid/ready stream interface used for the byte and record channels.
// Payload type is a parameter; no other dependencies.
`timescale 1ns / 1ps

interface rhep_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/rhep_front.sv
// Parser front: accepts block bytes, tracks the element state and
// classifies each byte into the records it causes. Uses rhep_pkg and rhep_stream_if.
`timescale 1ns / 1ps

module rhep_front import rhep_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	rhep_stream_if.sink     byte_ch,
	input  logic            q_full,
	output logic            q_push,
	output q_entry_t        q_entry
);

	phase_t      phase_q, ph_n;
	mode_t       mode_q, mode_n;
	logic [16:0] off_q, off_n, off_inc;
	logic [7:0]  id_q, id_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  rem_q, rem_n;
	logic [15:0] start_q, start_n;
	logic        acc;
	in_item_t    it;
	q_entry_t    ent;

	assign it          = byte_ch.data;
	assign byte_ch.ready = !q_full;
	assign acc         = byte_ch.valid && byte_ch.ready;
	assign off_inc     = off_q + 17'd1;

	// Advance the parse state by one byte
	always_comb begin
		ph_n    = phase_q;
		mode_n  = mode_q;
		id_n    = id_q;
		len_n   = len_q;
		rem_n   = rem_q;
		start_n = start_q;
		ent     = '0;

		// Classify the block on its first byte
		if (phase_q == PH_HDR && mode_q == MODE_NONE) begin
			if (it.profile == PROFILE_ONE) begin
				mode_n = MODE_ONE;
			end else if ((it.profile & PROFILE_TWO_MASK) == PROFILE_TWO) begin
				mode_n = MODE_TWO;
			end else begin
				mode_n = MODE_IGN;
				ph_n   = PH_SKIP;
			end
		end

		// Oversize block
		if ((mode_n inside {MODE_ONE, MODE_TWO}) && off_q >= 17'(MAX_BLOCK_BYTES)) begin
			ph_n = PH_BAD;
		end

		case (ph_n)
			PH_HDR: begin
				if (mode_n == MODE_ONE) begin
					if (it.ext_byte[7:4] == 4'd0) begin
						if (it.ext_byte[3:0] != 4'd0) begin
							ph_n = PH_BAD;
						end
					end else if (it.ext_byte[7:4] == STOP_ID) begin
						ph_n = PH_SKIP;
					end else begin
						id_n    = {4'd0, it.ext_byte[7:4]};
						len_n   = {4'd0, it.ext_byte[3:0]} + 8'd1;
						rem_n   = {4'd0, it.ext_byte[3:0]} + 8'd1;
						start_n = off_inc[15:0];
						ph_n    = PH_DATA;
					end
				end else if (mode_n == MODE_TWO) begin
					if (it.ext_byte != 8'd0) begin
						id_n = it.ext_byte;
						ph_n = PH_LEN;
					end
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_LEN: begin
				len_n   = it.ext_byte;
				start_n = off_inc[15:0];
				if (it.ext_byte == 8'd0) begin
					ent.elem_vld = 1'b1;
					ent.elem_id  = id_q;
					ent.elem_len = 8'd0;
					ent.elem_off = off_inc[15:0];
					ph_n         = PH_HDR;
				end else begin
					rem_n = it.ext_byte;
					ph_n  = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rem_q <= 8'd1) begin
					rem_n        = 8'd0;
					ent.elem_vld = 1'b1;
					ent.elem_id  = id_q;
					ent.elem_len = len_q;
					ent.elem_off = start_q;
					ph_n         = PH_HDR;
				end else begin
					rem_n = rem_q - 8'd1;
				end
			end
			PH_SKIP: begin
				ph_n = PH_SKIP;
			end
			default: begin
				ph_n = PH_BAD;
			end
		endcase

		off_n = (off_q < OFFSET_MAX) ? off_inc : off_q;

		// Close the block: status record and state clear
		if (it.end_of_block) begin
			ent.stat_vld = 1'b1;
			ent.stat_bad = (ph_n inside {PH_LEN, PH_DATA, PH_BAD});
			ph_n         = PH_HDR;
			mode_n       = MODE_NONE;
			off_n        = '0;
			id_n         = '0;
			len_n        = '0;
			rem_n        = '0;
			start_n      = '0;
		end
	end

	assign q_entry = ent;
	assign q_push  = acc && (ent.elem_vld || ent.stat_vld);

	// Hold state between bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			mode_q  <= MODE_NONE;
			off_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			start_q <= '0;
		end else if (acc) begin
			phase_q <= ph_n;
			mode_q  <= mode_n;
			off_q   <= off_n;
			id_q    <= id_n;
			len_q   <= len_n;
			rem_q   <= rem_n;
			start_q <= start_n;
		end
	end

	// A closing byte leaves the parser ready for a new block
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && it.end_of_block |=> phase_q == PH_HDR && mode_q == MODE_NONE && off_q == '0)
		else $error("block state not cleared after end of block");

	// Phase stays one-hot
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(phase_q))
		else $error("parse phase not one-hot");

endmodule

### rtl/rhep_queue.sv
// Short queue of per-byte record entries between parser front and output stage.
// Uses rhep_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rhep_queue import rhep_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output q_entry_t head
);

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != '0)
		else $error("pop from empty queue");

	// Never push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");

endmodule

### rtl/rhep_back.sv
// Output stage: unpacks queue entries into single records on the output channel,
// one record a cycle while the record channel is ready. Uses rhep_pkg and rhep_stream_if.
`timescale 1ns / 1ps

module rhep_back import rhep_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  q_entry_t       q_head,
	output logic           q_pop,
	rhep_stream_if.source  rec_ch
);

	logic load_en;
	logic out_vld_q;
	rec_t out_rec_q;
	logic pend_q;
	logic pend_bad_q;
	rec_t elem_rec, stat_rec, pend_rec;

	assign load_en = !out_vld_q || rec_ch.ready;
	assign q_pop   = load_en && !pend_q && q_not_empty;

	// Build candidate records
	always_comb begin
		elem_rec             = '0;
		elem_rec.record_type = REC_ELEMENT;
		elem_rec.ext_id      = q_head.elem_id;
		elem_rec.ext_len     = q_head.elem_len;
		elem_rec.data_offset = q_head.elem_off;
		elem_rec.run_last    = !q_head.stat_vld;

		stat_rec             = '0;
		stat_rec.record_type = REC_STATUS;
		stat_rec.status      = q_head.stat_bad;
		stat_rec.run_last    = 1'b1;

		pend_rec             = '0;
		pend_rec.record_type = REC_STATUS;
		pend_rec.status      = pend_bad_q;
		pend_rec.run_last    = 1'b1;
	end

	// Load the output register; hold a trailing status behind an element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_q     <= 1'b0;
			pend_bad_q <= 1'b0;
		end else if (load_en) begin
			if (pend_q) begin
				out_vld_q <= 1'b1;
				pend_q    <= 1'b0;
			end else if (q_not_empty) begin
				out_vld_q <= 1'b1;
				if (q_head.elem_vld) begin
					pend_q     <= q_head.stat_vld;
					pend_bad_q <= q_head.stat_bad;
				end
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_en) begin
			if (pend_q) begin
				out_rec_q <= pend_rec;
			end else if (q_head.elem_vld) begin
				out_rec_q <= elem_rec;
			end else begin
				out_rec_q <= stat_rec;
			end
		end
	end

	assign rec_ch.valid = out_vld_q;
	assign rec_ch.data  = out_rec_q;

	// A held status only follows an element still in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_vld_q && out_rec_q.record_type == REC_ELEMENT && !out_rec_q.run_last)
		else $error("pending status without element ahead");

	// Status records always close their run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_rec_q.record_type == REC_STATUS |-> out_rec_q.run_last)
		else $error("status record without run_last");

endmodule

### rtl/rtp_header_ext_parser_unit.sv
// RTP header-extension parser (one-byte and two-byte element forms).
// Throughput: one byte per cycle while the queue is not full; a byte that closes an
// element and the block together yields two records, which leave one after the other.
// Each record passes through the queue and then the output register; a second record
// of the same byte is held back and follows the first.
// Reset: arst_n clears parse state, queue and output register at once; no sweep.
`timescale 1ns / 1ps

module rtp_header_ext_parser_unit import rhep_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	rhep_stream_if.sink    ext_bytes,
	rhep_stream_if.source  records
);

	q_entry_t push_entry, head;
	logic     push, full, pop, not_empty;

	// Parse bytes into per-byte record entries
	rhep_front #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (ext_bytes),
		.q_full  (full),
		.q_push  (push),
		.q_entry (push_entry)
	);

	// Decouple parsing from output stalls
	rhep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Emit records one per cycle while the record channel is ready
	rhep_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_head      (head),
		.q_pop       (pop),
		.rec_ch      (records)
	);

endmodule

### tb/rtp_header_ext_parser_unit_test.sv
// Self-checking testbench for rtp_header_ext_parser_unit: random header-extension blocks.
// Predicts every record in a small scoreboard class. Depends on rhep_pkg and rhep_stream_if.
`timescale 1ns / 1ps

module rtp_header_ext_parser_unit_test import rhep_pkg::*;;

	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int DIRECTED_SPLIT   = 800;
	localparam int RANDOM_ITEMS     = 950;

	// Predict records of the parser and match them against the record channel
	class rhep_record_scoreboard;
		phase_t      phase;
		mode_t       mode;
		logic [16:0] offset;
		logic [7:0]  cur_id;
		logic [7:0]  cur_len;
		logic [7:0]  remaining;
		logic [15:0] start;
		rec_t        pending[$];
		int          mismatches;
		int          checked;

		function new();
			mismatches = 0;
			checked = 0;
			clear_block();
		endfunction

		function void clear_block();
			phase = PH_HDR;
			mode = MODE_NONE;
			offset = '0;
			cur_id = '0;
			cur_len = '0;
			remaining = '0;
			start = '0;
		endfunction

		function rec_t make_rec(logic typ, logic [7:0] id, logic [7:0] len,
				logic [15:0] off, logic bad);
			rec_t r;
			r.record_type = typ;
			r.ext_id = id;
			r.ext_len = len;
			r.data_offset = off;
			r.status = bad;
			r.run_last = 1'b0;
			return r;
		endfunction

		// Advance the parse state by one accepted byte and queue its records
		function void note_byte(in_item_t it);
			rec_t run[$];
			logic [3:0] id_nib;
			logic [3:0] len_nib;
			logic bad;
			id_nib = it.ext_byte[7:4];
			len_nib = it.ext_byte[3:0];

			// pick the element form on the first byte of a block
			if (phase == PH_HDR && mode == MODE_NONE) begin
				if (it.profile == PROFILE_ONE)
					mode = MODE_ONE;
				else if ((it.profile & PROFILE_TWO_MASK) == PROFILE_TWO)
					mode = MODE_TWO;
				else begin
					mode = MODE_IGN;
					phase = PH_SKIP;
				end
			end

			if ((mode == MODE_ONE || mode == MODE_TWO) &&
					offset >= 17'(MAX_BLOCK_BYTES_DEF))
				phase = PH_BAD;

			case (phase)
				PH_HDR: begin
					if (mode == MODE_ONE) begin
						if (id_nib == 4'h0) begin
							if (len_nib != 4'h0)
								phase = PH_BAD;
						end else if (id_nib == STOP_ID) begin
							phase = PH_SKIP;
						end else begin
							cur_id = {4'h0, id_nib};
							cur_len = {4'h0, len_nib} + 8'd1;
							remaining = cur_len;
							start = offset[15:0] + 16'd1;
							phase = PH_DATA;
						end
					end else if (mode == MODE_TWO) begin
						if (it.ext_byte != 8'h00) begin
							cur_id = it.ext_byte;
							phase = PH_LEN;
						end
					end else begin
						phase = PH_SKIP;
					end
				end
				PH_LEN: begin
					cur_len = it.ext_byte;
					start = offset[15:0] + 16'd1;
					if (it.ext_byte == 8'h00) begin
						run.push_back(make_rec(REC_ELEMENT, cur_id, 8'h00, start, 1'b0));
						phase = PH_HDR;
					end else begin
						remaining = it.ext_byte;
						phase = PH_DATA;
					end
				end
				PH_DATA: begin
					if (remaining <= 8'd1) begin
						remaining = '0;
						run.push_back(make_rec(REC_ELEMENT, cur_id, cur_len, start, 1'b0));
						phase = PH_HDR;
					end else begin
						remaining = remaining - 8'd1;
					end
				end
				PH_SKIP: ;
				default: phase = PH_BAD;
			endcase

			if (offset != OFFSET_MAX)
				offset = offset + 17'd1;

			// close the block with its status
			if (it.end_of_block) begin
				bad = (phase == PH_LEN || phase == PH_DATA || phase == PH_BAD);
				run.push_back(make_rec(REC_STATUS, 8'h00, 8'h00, 16'h0000, bad));
				clear_block();
			end

			if (run.size() > 0)
				run[run.size() - 1].run_last = 1'b1;
			foreach (run[i])
				pending.push_back(run[i]);
		endfunction

		function void flag(string what, rec_t want, rec_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t record %0d %s: expected type=%0d id=%0d len=%0d off=%0d st=%0d last=%0d",
					$realtime, checked, what,
					want.record_type, want.ext_id, want.ext_len, want.data_offset,
					want.status, want.run_last);
				$display("    got type=%0d id=%0d len=%0d off=%0d st=%0d last=%0d",
					got.record_type, got.ext_id, got.ext_len, got.data_offset,
					got.status, got.run_last);
			end
		endfunction

		// Compare one accepted record with the oldest prediction
		function void check_record(rec_t got);
			rec_t want;
			checked++;
			if (pending.size() == 0) begin
				flag("unexpected", '0, got);
				return;
			end
			want = pending.pop_front();
			if (got.record_type !== want.record_type || got.ext_id !== want.ext_id ||
					got.ext_len !== want.ext_len || got.data_offset !== want.data_offset ||
					got.status !== want.status || got.run_last !== want.run_last)
				flag("mismatch", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic idling;
	int   cycles;
	logic [7:0] blk_bytes[$];
	rhep_record_scoreboard sb;

	rhep_stream_if #(.T(in_item_t)) byte_ch ();
	rhep_stream_if #(.T(rec_t))     rec_ch ();

	rtp_header_ext_parser_unit #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES_DEF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.ext_bytes(byte_ch),
		.records(rec_ch)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Check every accepted record
	always @(posedge clk) begin
		if (arst_n && rec_ch.valid && rec_ch.ready)
			sb.check_record(rec_ch.data);
	end

	// Stall the record channel in random bursts
	initial begin
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 7) == 0) begin
				rec_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				rec_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one byte, with an optional gap ahead of it; start and end at a falling edge
	task automatic send_byte(in_item_t it);
		if (idling && $urandom_range(0, 7) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data <= it;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		sb.note_byte(it);
		@(negedge clk);
	endtask

	// Send blk_bytes as one block; the profile only matters on the first byte
	task automatic send_block(logic [15:0] prof);
		in_item_t it;
		foreach (blk_bytes[i]) begin
			it.ext_byte = blk_bytes[i];
			it.profile = (i == 0) ? prof : 16'($urandom);
			it.end_of_block = (i == blk_bytes.size() - 1);
			send_byte(it);
		end
	endtask

	// Build a mostly well-formed block with random content, sometimes broken
	task automatic gen_random_block(output logic [15:0] prof);
		int kind;
		int len;
		int r;
		blk_bytes.delete();
		kind = $urandom_range(0, 19);
		if (kind < 9) begin
			prof = PROFILE_ONE;
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 9) == 0) begin
					blk_bytes.push_back(8'h00);
				end else begin
					len = ($urandom_range(0, 3) == 0) ?
						$urandom_range(1, 16) : $urandom_range(1, 4);
					blk_bytes.push_back({4'($urandom_range(1, 14)), 4'(len - 1)});
					repeat (len) blk_bytes.push_back(8'($urandom));
				end
			end
			r = $urandom_range(0, 9);
			if (r == 0) begin
				blk_bytes.push_back({STOP_ID, 4'($urandom)});
				repeat ($urandom_range(0, 3)) blk_bytes.push_back(8'($urandom));
			end else if (r == 1) begin
				blk_bytes.push_back({4'h0, 4'($urandom_range(1, 15))});
				repeat ($urandom_range(0, 2)) blk_bytes.push_back(8'($urandom));
			end
		end else if (kind < 17) begin
			prof = PROFILE_TWO | 16'($urandom_range(0, 15));
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(0, 9) == 0) begin
					blk_bytes.push_back(8'h00);
				end else begin
					r = $urandom_range(0, 19);
					if (r < 3)
						len = 0;
					else if (r == 3)
						len = $urandom_range(17, 255);
					else
						len = $urandom_range(1, 6);
					blk_bytes.push_back(8'($urandom_range(1, 255)));
					blk_bytes.push_back(8'(len));
					repeat (len) blk_bytes.push_back(8'($urandom));
				end
			end
		end else if (kind < 19) begin
			do
				prof = 16'($urandom);
			while (prof == PROFILE_ONE || (prof & PROFILE_TWO_MASK) == PROFILE_TWO);
			repeat ($urandom_range(1, 6)) blk_bytes.push_back(8'($urandom));
		end else begin
			// noise under a valid profile
			prof = $urandom_range(0, 1) ?
				PROFILE_ONE : (PROFILE_TWO | 16'($urandom_range(0, 15)));
			repeat ($urandom_range(1, 8)) blk_bytes.push_back(8'($urandom));
		end
		// cut the block short now and then
		if (kind < 17 && blk_bytes.size() > 1 && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, blk_bytes.size() - 1)) void'(blk_bytes.pop_back());
		if (blk_bytes.size() == 0)
			blk_bytes.push_back(8'($urandom));
	endtask

	initial begin
		logic [15:0] prof;
		int random_items;
		clk = 1'b0;
		arst_n = 1'b0;
		idling = 1'b0;
		cycles = 0;
		random_items = 0;
		byte_ch.valid = 1'b0;
		byte_ch.data = '0;
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one-byte form: padding, element, stop marker with trailing bytes
		blk_bytes = '{8'h00, 8'h10, 8'hFF, 8'hF0, 8'hAB};
		send_block(PROFILE_ONE);
		// one-byte form: id 0 with a nonzero length
		blk_bytes = '{8'h05};
		send_block(PROFILE_ONE);
		// one-byte form: block ends inside element data
		blk_bytes = '{8'h21, 8'h00};
		send_block(PROFILE_ONE);
		// two-byte form: padding, empty element, element closing with the block
		blk_bytes = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h01, 8'h77};
		send_block(16'h100F);
		// two-byte form: block ends after the id byte
		blk_bytes = '{8'h05};
		send_block(PROFILE_TWO);
		// ignored profiles
		blk_bytes = '{8'h12, 8'h34};
		send_block(16'hFFFF);
		blk_bytes = '{8'hFF};
		send_block(16'h0000);
		blk_bytes = '{8'h00};
		send_block(16'h1010);

		// random blocks with idling on both sides
		while (random_items < DIRECTED_SPLIT) begin
			idling = ($urandom_range(0, 4) != 0);
			gen_random_block(prof);
			random_items += blk_bytes.size();
			send_block(prof);
		end

		// last stretch at full rate
		idling = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			gen_random_block(prof);
			random_items += blk_bytes.size();
			send_block(prof);
		end
		byte_ch.valid <= 1'b0;

		// drain and settle
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.mismatches++;
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
rtl/rhep_pkg.sv
rtl/rhep_stream_if.sv
rtl/rhep_front.sv
rtl/rhep_queue.sv
rtl/rhep_back.sv
rtl/rtp_header_ext_parser_unit.sv
tb/rtp_header_ext_parser_unit_test.sv
